>>> hw/rtl/mbrot_pkg.sv
// shared types, constants and fixed-point helpers for the mandelbrot pixel evaluator
package mbrot_pkg;

  localparam int PIX_W       = 10;
  localparam int Q_W         = 40;
  localparam int STEP_W      = 39;
  localparam int CNT_W       = 12;
  localparam int COLOR_W     = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 40;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int PROD_W      = PIX_W + STEP_W;
  localparam int WIDE_W      = 52;
  localparam int COLOR_MOD   = 15;

  localparam logic [CFG_IDX_W-1:0] REG_CORNER_REAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_IMAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd4;

  localparam logic signed [Q_W-1:0] RST_CORNER_REAL = -40'sd10307921510;
  localparam logic signed [Q_W-1:0] RST_CORNER_IMAG = -40'sd7301444403;
  localparam logic [STEP_W-1:0]     RST_STEP_REAL   = 39'd229064922;
  localparam logic [STEP_W-1:0]     RST_STEP_IMAG   = 39'd572662306;
  localparam logic [CNT_W-1:0]      RST_MAX_ITER    = 12'd100;

  localparam logic signed [Q_W-1:0]    Q_MAX   = 40'sh7F_FFFF_FFFF;
  localparam logic signed [Q_W-1:0]    Q_MIN   = -40'sd549755813888;
  localparam logic signed [WIDE_W-1:0] WIDE_HI = 52'sd549755813887;
  localparam logic signed [WIDE_W-1:0] WIDE_LO = -52'sd549755813888;
  localparam logic [47:0]              MAG_POS = 48'h7F_FFFF_FFFF;
  localparam logic [47:0]              MAG_NEG = 48'h80_0000_0000;
  localparam logic [41:0]              FOUR_Q  = 42'h4_0000_0000;

  typedef struct packed {
    logic signed [Q_W-1:0] re;
    logic signed [Q_W-1:0] im;
  } cpoint_t;

  typedef struct packed {
    logic signed [Q_W-1:0] corner_real;
    logic signed [Q_W-1:0] corner_imag;
    logic [STEP_W-1:0]     step_real;
    logic [STEP_W-1:0]     step_imag;
    logic [CNT_W-1:0]      max_iterations;
  } cfg_t;

  // partial products of two 40-bit magnitudes split at bit 32
  typedef struct packed {
    logic [15:0] hh;
    logic [39:0] c1;
    logic [39:0] c2;
    logic [63:0] ll;
  } part_t;

  function automatic logic signed [Q_W-1:0] sat_q(logic signed [WIDE_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > WIDE_HI) r = Q_MAX;
    else if (v < WIDE_LO) r = Q_MIN;
    else r = v[Q_W-1:0];
    return r;
  endfunction

  function automatic logic [Q_W-1:0] mag_q(logic signed [Q_W-1:0] v);
    logic [Q_W-1:0] r;
    if (v[Q_W-1]) r = 40'd0 - v;
    else r = v;
    return r;
  endfunction

  function automatic part_t part_mul(logic [Q_W-1:0] a, logic [Q_W-1:0] b);
    part_t p;
    p.hh = 16'(a[39:32]) * 16'(b[39:32]);
    p.c1 = 40'(a[39:32]) * 40'(b[31:0]);
    p.c2 = 40'(a[31:0]) * 40'(b[39:32]);
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    return p;
  endfunction

  // sum partials, drop 31 or 32 low bits, apply sign and saturate
  function automatic logic signed [Q_W-1:0] prod_sat(part_t p, logic sh31, logic neg);
    logic [78:0]           full;
    logic [47:0]           m;
    logic signed [Q_W-1:0] r;
    full = (79'(p.hh) << 64) + (79'(p.c1) << 32) + (79'(p.c2) << 32) + 79'(p.ll);
    m = sh31 ? full[78:31] : {1'b0, full[78:32]};
    if (neg) begin
      if (m > MAG_NEG) r = Q_MIN;
      else r = $signed(40'd0 - m[Q_W-1:0]);
    end else begin
      if (m > MAG_POS) r = Q_MAX;
      else r = $signed(m[Q_W-1:0]);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/mbrot_front.sv
// front end: takes pixel requests, wraps indices to the grid and forms the point c
module mbrot_front #(
  parameter int GRID_DIM = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mbrot_pkg::cfg_t                       cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [mbrot_pkg::PIX_W-1:0]           pixel_column,
  input  logic [mbrot_pkg::PIX_W-1:0]           pixel_row,
  output logic                                  q_valid,
  input  logic                                  q_ready,
  output mbrot_pkg::cpoint_t                    q_data
);
  import mbrot_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_ADD  = 3'b100
  } fstate_t;

  fstate_t           state;
  logic [PIX_W-1:0]  col;
  logic [PIX_W-1:0]  row;
  logic [PROD_W-1:0] prod_re;
  logic [PROD_W-1:0] prod_im;

  // restoring reduction by shifted copies of the grid size
  function automatic logic [PIX_W-1:0] grid_wrap(logic [PIX_W-1:0] v);
    logic [23:0] r;
    logic [23:0] d;
    r = 24'(v);
    for (int k = 6; k >= 0; k--) begin
      d = 24'(GRID_DIM) << k;
      if (d <= r) r = r - d;
    end
    return r[PIX_W-1:0];
  endfunction

  assign in_ready  = (state == F_IDLE);
  assign q_valid   = (state == F_ADD);
  assign q_data.re = sat_q(WIDE_W'(cfg.corner_real) + $signed({3'b000, prod_re}));
  assign q_data.im = sat_q(WIDE_W'(cfg.corner_imag) + $signed({3'b000, prod_im}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            col   <= grid_wrap(pixel_column);
            row   <= grid_wrap(pixel_row);
            state <= F_MUL;
          end
        end
        F_MUL: begin
          prod_re <= PROD_W'(col) * PROD_W'(cfg.step_real);
          prod_im <= PROD_W'(row) * PROD_W'(cfg.step_imag);
          state   <= F_ADD;
        end
        F_ADD: begin
          if (q_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/mbrot_queue.sv
// two-entry queue of points between front end and iteration engine
module mbrot_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mbrot_pkg::cpoint_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mbrot_pkg::cpoint_t out_data
);
  import mbrot_pkg::*;

  cpoint_t    slots [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= in_data;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> hw/rtl/mbrot_iter.sv
// iteration engine: runs z = z^2 + c and holds the result register
module mbrot_iter (
  input  logic                          clk,
  input  logic                          rst,
  input  mbrot_pkg::cfg_t               cfg,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  mbrot_pkg::cpoint_t            q_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mbrot_pkg::CNT_W-1:0]   escape_value,
  output logic [mbrot_pkg::COLOR_W-1:0] color_index
);
  import mbrot_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_CHECK = 4'b0010,
    B_MUL   = 4'b0100,
    B_COMB  = 4'b1000
  } bstate_t;

  bstate_t               state;
  logic signed [Q_W-1:0] cr;
  logic signed [Q_W-1:0] ci;
  logic signed [Q_W-1:0] x;
  logic signed [Q_W-1:0] y;
  logic signed [Q_W-1:0] x2;
  logic signed [Q_W-1:0] y2;
  logic signed [Q_W-1:0] xy2;
  part_t                 px;
  part_t                 py;
  part_t                 pxy;
  logic                  neg_xy;
  logic [CNT_W-1:0]      n;
  logic [COLOR_W-1:0]    nmod;

  logic                  cont;
  logic                  out_free;
  logic                  load_out;
  logic [41:0]           radius;
  logic [Q_W-1:0]        mx;
  logic [Q_W-1:0]        my;
  logic signed [Q_W-1:0] x_next;
  logic signed [Q_W-1:0] y_next;
  logic [COLOR_W-1:0]    nmod_next;
  logic [CNT_W-1:0]      escape_next;
  logic [COLOR_W-1:0]    color_next;

  always_comb begin
    radius      = {2'b00, x2} + {2'b00, y2};
    cont        = (n < cfg.max_iterations) && (radius <= FOUR_Q);
    out_free    = !out_valid || out_ready;
    load_out    = (state == B_CHECK) && !cont && out_free;
    mx          = mag_q(x);
    my          = mag_q(y);
    x_next      = sat_q(WIDE_W'(x2) - WIDE_W'(y2) + WIDE_W'(cr));
    y_next      = sat_q(WIDE_W'(xy2) + WIDE_W'(ci));
    nmod_next   = (nmod == COLOR_W'(COLOR_MOD - 1)) ? '0 : nmod + 1'b1;
    escape_next = (n == cfg.max_iterations) ? '0 : n + 1'b1;
    color_next  = (escape_next == '0) ? '0 : nmod_next + 1'b1;
  end

  assign q_ready = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            cr    <= q_data.re;
            ci    <= q_data.im;
            x     <= '0;
            y     <= '0;
            x2    <= '0;
            y2    <= '0;
            xy2   <= '0;
            n     <= '0;
            nmod  <= '0;
            state <= B_CHECK;
          end
        end
        B_CHECK: begin
          if (cont) begin
            x     <= x_next;
            y     <= y_next;
            n     <= n + 1'b1;
            nmod  <= nmod_next;
            state <= B_MUL;
          end else if (out_free) begin
            escape_value <= escape_next;
            color_index  <= color_next;
            state        <= B_IDLE;
          end
        end
        B_MUL: begin
          px     <= part_mul(mx, mx);
          py     <= part_mul(my, my);
          pxy    <= part_mul(mx, my);
          neg_xy <= x[Q_W-1] ^ y[Q_W-1];
          state  <= B_COMB;
        end
        B_COMB: begin
          x2    <= prod_sat(px, 1'b0, 1'b0);
          y2    <= prod_sat(py, 1'b0, 1'b0);
          xy2   <= prod_sat(pxy, 1'b1, neg_xy);
          state <= B_CHECK;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/mandelbrot_escape_time_pixel.sv
// top level of the mandelbrot escape-time pixel evaluator
// front end: wrap, multiply and add steps per pixel request, one request at a time
// iteration engine: multiply, combine and update steps per iteration, plus load and
// final test; it takes a new point only after the last result is in the output register
// a two-entry queue decouples the parts; synchronous reset clears control and loads
// register defaults
module mandelbrot_escape_time_pixel #(
  parameter int GRID_DIM = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mbrot_pkg::IN_TDATA_W-1:0]   s_tdata,   // pixel_column, pixel_row
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mbrot_pkg::OUT_TDATA_W-1:0]  m_tdata,   // escape_value, color_index
  input  logic                               cfg_wr_en,
  input  logic [mbrot_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbrot_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mbrot_pkg::*;

  cfg_t               cfg;
  logic               fq_valid;
  logic               fq_ready;
  cpoint_t            fq_data;
  logic               qb_valid;
  logic               qb_ready;
  cpoint_t            qb_data;
  logic [CNT_W-1:0]   escape_value;
  logic [COLOR_W-1:0] color_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.corner_real    <= RST_CORNER_REAL;
      cfg.corner_imag    <= RST_CORNER_IMAG;
      cfg.step_real      <= RST_STEP_REAL;
      cfg.step_imag      <= RST_STEP_IMAG;
      cfg.max_iterations <= RST_MAX_ITER;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CORNER_REAL: cfg.corner_real    <= $signed(cfg_wdata[Q_W-1:0]);
        REG_CORNER_IMAG: cfg.corner_imag    <= $signed(cfg_wdata[Q_W-1:0]);
        REG_STEP_REAL:   cfg.step_real      <= cfg_wdata[STEP_W-1:0];
        REG_STEP_IMAG:   cfg.step_imag      <= cfg_wdata[STEP_W-1:0];
        REG_MAX_ITER:    cfg.max_iterations <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  mbrot_front #(
    .GRID_DIM (GRID_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .pixel_column (s_tdata[PIX_W-1:0]),
    .pixel_row    (s_tdata[2*PIX_W-1:PIX_W]),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_data       (fq_data)
  );

  mbrot_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  mbrot_iter u_iter (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (qb_valid),
    .q_ready      (qb_ready),
    .q_data       (qb_data),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .escape_value (escape_value),
    .color_index  (color_index)
  );

  assign m_tdata = {color_index, escape_value};

endmodule

>>> hw/rtl/mbrot_chk.sv
// port-level checks for the mandelbrot pixel evaluator, bound to the top level
module mbrot_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [mbrot_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import mbrot_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // color is zero exactly for points that stay inside
  a_color_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[11:0] == 12'd0) == (m_tdata[15:12] == 4'd0)))
    else $error("color and escape value disagree on inside");

  // z starts at zero, so at least one iteration runs before an escape
  a_no_escape_one: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[11:0] != 12'd1)
    else $error("escape value of one");

  // reset leaves no result pending and the request side open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

endmodule

bind mandelbrot_escape_time_pixel mbrot_chk u_chk (.*);
